// ===== src/ftgd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the frame timestamp gap detector.
// No dependencies; used by frame_timestamp_gap_detector.
package ftgd_pkg;

    localparam int FRAME_INDEX_BITS = 32;   // frame index wraps at this width
    localparam int TICK_W           = 64;   // timestamp width in ticks
    localparam int IVL_W            = 32;   // interval register width
    localparam int CNT32_W          = 32;   // output count width
    localparam int DIV_CNT_W        = $clog2(TICK_W);
    localparam int OUT_TDATA_W      = 3 * CNT32_W + 2 * CNT32_W + TICK_W;

    localparam logic [IVL_W-1:0]   INTERVAL_RESET = 32'd166667;
    localparam logic [CNT32_W-1:0] SAT32          = '1;

    typedef logic [FRAME_INDEX_BITS-1:0] t_frame_idx;
    typedef logic [TICK_W-1:0]           t_tick;
    typedef logic [IVL_W-1:0]            t_interval;
    typedef logic [CNT32_W-1:0]          t_count;

    // Saturating 32-bit add
    function automatic t_count sat_add(input t_count a, input t_count b);
        logic [CNT32_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT32_W] ? SAT32 : s[CNT32_W-1:0];
    endfunction

endpackage

// ===== src/frame_timestamp_gap_detector.sv =====
`timescale 1ns / 1ps
// A request that finds no gap steps through ST_MUL, ST_CMP and ST_FIN, where its result
// (if any) is registered; the next request is taken once the sequencer returns to ST_IDLE.
// A request that finds a gap also runs a 64-step serial divider and a rounding state before ST_FIN.
// A previous result still waiting on m_axis_tready holds the last step and adds its wait.
// Reset (i_rst_n low, synchronous) clears all frame state and totals and loads the
// interval register with 166667 ticks.
//
// Top level of the frame timestamp gap detector; depends on ftgd_pkg.

module frame_timestamp_gap_detector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: frame_interval_ticks
    input  logic                           i_cfg_we,
    input  logic [ftgd_pkg::IVL_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ftgd_pkg::TICK_W-1:0]    s_axis_tdata,   // [63:0] tick_stamp
    input  logic                           s_axis_tlast,   // last_item
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] gap_first_frame, [63:32] gap_last_frame, [127:64] gap_ticks,
    // [159:128] missing_frames, [191:160] gap_total, [223:192] missing_total
    output logic [ftgd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser,   // gap_found
    output logic                           m_axis_tlast    // sequence_done
);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a request
    localparam logic [2:0] ST_MUL  = 3'd1;  // interval * span
    localparam logic [2:0] ST_CMP  = 3'd2;  // threshold compare
    localparam logic [2:0] ST_DIV  = 3'd3;  // one quotient bit per cycle
    localparam logic [2:0] ST_RND  = 3'd4;  // round and form missing count
    localparam logic [2:0] ST_FIN  = 3'd5;  // update totals, emit result

    localparam int TW = ftgd_pkg::TICK_W;

    // Control state
    logic [2:0]                         r_state;
    ftgd_pkg::t_interval                r_cfg_interval;
    ftgd_pkg::t_frame_idx               r_frame_counter;
    ftgd_pkg::t_tick                    r_prev_tick;
    ftgd_pkg::t_frame_idx               r_prev_frame;
    logic                               r_have_prev;
    ftgd_pkg::t_count                   r_gaps_counted;
    ftgd_pkg::t_count                   r_missing_counted;
    logic                               r_out_valid;
    logic [ftgd_pkg::DIV_CNT_W-1:0]     r_cnt;

    // Per-request working registers
    logic                               r_last;
    logic                               r_check;
    logic                               r_gap;
    ftgd_pkg::t_tick                    r_delta;
    ftgd_pkg::t_frame_idx               r_span;
    ftgd_pkg::t_frame_idx               r_first;
    ftgd_pkg::t_frame_idx               r_cur_frame;
    logic [TW-1:0]                      r_prod;
    logic [TW-1:0]                      r_quo;
    ftgd_pkg::t_interval                r_rem;
    ftgd_pkg::t_count                   r_missing;

    // Output holding register
    logic [ftgd_pkg::OUT_TDATA_W-1:0]   r_out_tdata;
    logic                               r_out_tuser;
    logic                               r_out_tlast;

    logic                               w_accept;
    ftgd_pkg::t_interval                w_interval;
    logic [TW:0]                        w_thr;
    logic                               w_gap;
    logic [ftgd_pkg::IVL_W:0]           w_rem_sh;
    logic [ftgd_pkg::IVL_W+1:0]         w_diff;
    logic                               w_ge;
    ftgd_pkg::t_interval                n_rem;
    logic [TW-1:0]                      n_quo;
    logic                               w_rnd_up;
    logic [TW:0]                        w_rounded;
    logic [TW:0]                        w_span_ext;
    logic [TW:0]                        w_m;
    ftgd_pkg::t_count                   n_missing;
    logic                               w_emit;
    logic                               w_out_free;
    logic                               w_release;
    ftgd_pkg::t_count                   n_gaps;
    ftgd_pkg::t_count                   n_missing_total;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // A zero interval counts as one tick
    assign w_interval = (r_cfg_interval == '0) ? ftgd_pkg::IVL_W'(1) : r_cfg_interval;

    // Threshold = 1.5 * interval * span; a carry out means it can never be exceeded
    assign w_thr = {1'b0, r_prod} + {2'b0, r_prod[TW-1:1]};
    assign w_gap = r_check && !w_thr[TW] && (r_delta > w_thr[TW-1:0]);

    // Restoring divider step: bring in the next dividend bit, subtract if it fits
    assign w_rem_sh = {r_rem, r_quo[TW-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b0, w_interval};
    assign w_ge     = !w_diff[ftgd_pkg::IVL_W+1];
    assign n_rem    = w_ge ? w_diff[ftgd_pkg::IVL_W-1:0] : w_rem_sh[ftgd_pkg::IVL_W-1:0];
    assign n_quo    = {r_quo[TW-2:0], w_ge};

    // Round half up: remainder >= interval - remainder
    assign w_rnd_up   = ({r_rem, 1'b0} >= {1'b0, w_interval});
    assign w_rounded  = {1'b0, r_quo} + (TW+1)'(w_rnd_up);
    assign w_span_ext = (TW+1)'(r_span);
    assign w_m        = (w_rounded > w_span_ext + (TW+1)'(1)) ?
                        (w_rounded - w_span_ext) : (TW+1)'(1);
    assign n_missing  = (|w_m[TW:ftgd_pkg::CNT32_W]) ? ftgd_pkg::SAT32
                                                      : w_m[ftgd_pkg::CNT32_W-1:0];

    // Result release: a gap or the last item emits, once the holding register is free
    assign w_emit     = r_gap || r_last;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_release  = (r_state == ST_FIN) && w_emit && w_out_free;

    assign n_gaps          = r_gap ? ftgd_pkg::sat_add(r_gaps_counted, ftgd_pkg::t_count'(1))
                                   : r_gaps_counted;
    assign n_missing_total = r_gap ? ftgd_pkg::sat_add(r_missing_counted, r_missing)
                                   : r_missing_counted;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_cfg_interval    <= ftgd_pkg::INTERVAL_RESET;
            r_frame_counter   <= '0;
            r_prev_tick       <= '0;
            r_prev_frame      <= '0;
            r_have_prev       <= 1'b0;
            r_gaps_counted    <= '0;
            r_missing_counted <= '0;
            r_out_valid       <= 1'b0;
            r_cnt             <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_interval <= i_cfg_wdata;
            end
            // Load a new result, else drop the held one once it is taken
            if (w_release) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        // Advance the frame index and record a stamped frame right away
                        r_frame_counter <= r_frame_counter + ftgd_pkg::t_frame_idx'(1);
                        if (s_axis_tdata != '0) begin
                            r_prev_tick  <= s_axis_tdata;
                            r_prev_frame <= r_frame_counter;
                            r_have_prev  <= 1'b1;
                        end
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    r_cnt   <= '1;
                    r_state <= w_gap ? ST_DIV : ST_FIN;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - ftgd_pkg::DIV_CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= ST_RND;
                    end
                end
                ST_RND: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (!w_emit) begin
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        if (r_last) begin
                            // End of sequence: drop all frame state and totals
                            r_frame_counter   <= '0;
                            r_prev_tick       <= '0;
                            r_prev_frame      <= '0;
                            r_have_prev       <= 1'b0;
                            r_gaps_counted    <= '0;
                            r_missing_counted <= '0;
                        end else begin
                            r_gaps_counted    <= n_gaps;
                            r_missing_counted <= n_missing_total;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Working and output payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_last      <= s_axis_tlast;
                    r_check     <= (s_axis_tdata != '0) && r_have_prev;
                    r_delta     <= s_axis_tdata - r_prev_tick;
                    r_span      <= r_frame_counter - r_prev_frame;
                    r_first     <= r_prev_frame + ftgd_pkg::t_frame_idx'(1);
                    r_cur_frame <= r_frame_counter;
                end
            end
            ST_MUL: begin
                r_prod <= TW'(w_interval) * TW'(r_span);
            end
            ST_CMP: begin
                r_gap <= w_gap;
                r_quo <= r_delta;
                r_rem <= '0;
            end
            ST_DIV: begin
                r_quo <= n_quo;
                r_rem <= n_rem;
            end
            ST_RND: begin
                r_missing <= n_missing;
            end
            ST_FIN: begin
                if (w_emit && w_out_free) begin
                    r_out_tuser <= r_gap;
                    r_out_tlast <= r_last;
                    if (r_gap) begin
                        r_out_tdata <= {n_missing_total, n_gaps, r_missing, r_delta,
                                        ftgd_pkg::t_count'(r_cur_frame),
                                        ftgd_pkg::t_count'(r_first)};
                    end else begin
                        r_out_tdata <= {n_missing_total, n_gaps,
                                        (ftgd_pkg::OUT_TDATA_W - 2 * ftgd_pkg::CNT32_W)'(0)};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;
    assign m_axis_tlast  = r_out_tlast;

`ifndef SYNTH
    // A stamped request always becomes the reference for the next check
    a_stamp_recorded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tdata != '0) |=> r_have_prev)
        else $error("stamped request did not update previous-frame state");

    // A reported gap never claims zero missing frames
    a_gap_missing_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_tuser) |-> (r_out_tdata[159:128] != '0))
        else $error("gap result with zero missing frames");

    // Totals only move when a result is released
    a_totals_only_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_FIN) |=> ($stable(r_gaps_counted) && $stable(r_missing_counted)))
        else $error("running totals changed outside result release");
`endif

endmodule
